// ===== rtl/bfit_pkg.sv =====
`default_nettype none

package bfit_pkg;

  typedef struct packed {
    logic        is_ipv4;
    logic        has_ports;
    logic        is_tcp;
    logic        syn_flag;
    logic        ack_flag;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] tcp_seq;
  } bfit_req_t;

  typedef struct packed {
    logic        has_id;
    logic [31:0] conn_id;
    logic        table_full;
  } bfit_rsp_t;

  // One table slot: flow key in the direction of the first packet, id and sequence.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] conn_id;
    logic [31:0] seq;
  } bfit_entry_t;

  // Matches the stored key in either direction.
  function automatic logic flow_match(bfit_entry_t ent, bfit_req_t req);
    logic fwd;
    logic bwd;
    fwd = (ent.src_addr == req.src_addr) && (ent.dst_addr == req.dst_addr) &&
          (ent.src_port == req.src_port) && (ent.dst_port == req.dst_port);
    bwd = (ent.src_addr == req.dst_addr) && (ent.dst_addr == req.src_addr) &&
          (ent.src_port == req.dst_port) && (ent.dst_port == req.src_port);
    return fwd || bwd;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bidirectional_flow_id_table_core.sv =====
`default_nettype none
// Channel   Signals                                   Payload
// -------   ----------------------------------------  ----------
// input     in_valid_i / in_ready_o / in_data_i       bfit_req_t
// output    out_valid_o / out_ready_i / out_data_o    bfit_rsp_t
//
// One packet at a time. A packet with IPv4 and ports is checked against the N
// filled slots (N at most FLOW_SLOTS): the scan reads one slot per cycle from the
// single-port table memory and stops at a match, then the final state decides and
// writes back. Other packets go straight to the final state. Slots fill in order
// and are never freed, so a fill count marks the valid slots; reset clears it and
// the id counter. The result sits in an output register; a stalled output holds
// the next packet in its final state until the register frees up.
module bidirectional_flow_id_table_core
  import bfit_pkg::*;
#(
  parameter int FLOW_SLOTS = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire bfit_req_t in_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output bfit_rsp_t  out_data_o
);

  localparam int IDX_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CNT_W = $clog2(FLOW_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  bfit_req_t        req_q, req_d;
  logic             bypass_q, bypass_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [31:0]      ctr_q, ctr_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  bfit_entry_t      hit_ent_q, hit_ent_d;
  logic             out_valid_q, out_valid_d;
  bfit_rsp_t        out_data_q, out_data_d;

  bfit_entry_t      flow_mem_q [FLOW_SLOTS];
  bfit_entry_t      mem_rdata_q;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  bfit_entry_t      mem_wdata;

  logic             out_free;
  logic             retire;
  logic [31:0]      ctr_inc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign ctr_inc     = ctr_q + 32'd1;
  assign retire      = req_q.is_tcp && req_q.syn_flag && !req_q.ack_flag &&
                       (hit_ent_q.seq != req_q.tcp_seq);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    bypass_d    = bypass_q;
    fill_d      = fill_q;
    ctr_d       = ctr_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_wdata   = hit_ent_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          bypass_d = !(in_data_i.is_ipv4 && in_data_i.has_ports);
          hit_d    = 1'b0;
          rd_idx_d = '0;
          state_d  = (in_data_i.is_ipv4 && in_data_i.has_ports) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        // Reads are issued one slot ahead of the compare.
        if (rd_idx_q < fill_q) begin
          mem_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end
        if (cmp_vld_q && flow_match(mem_rdata_q, req_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          hit_ent_d = mem_rdata_q;
          cmp_vld_d = 1'b0;
          state_d   = S_FIN;
        end else if (!cmp_vld_q && (rd_idx_q >= fill_q)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          state_d     = S_IDLE;
          if (bypass_q) begin
            out_data_d = '0;
          end else if (hit_q) begin
            out_data_d.has_id  = 1'b1;
            out_data_d.conn_id = hit_ent_q.conn_id;
            if (retire) begin
              ctr_d               = ctr_inc;
              mem_we              = 1'b1;
              mem_waddr           = hit_idx_q;
              mem_wdata           = hit_ent_q;
              mem_wdata.conn_id   = ctr_inc;
              mem_wdata.seq       = req_q.tcp_seq;
              out_data_d.conn_id  = ctr_inc;
            end
          end else if (fill_q == CNT_W'(FLOW_SLOTS)) begin
            out_data_d.table_full = 1'b1;
          end else begin
            ctr_d              = ctr_inc;
            fill_d             = fill_q + CNT_W'(1);
            mem_we             = 1'b1;
            mem_waddr          = fill_q[IDX_W-1:0];
            mem_wdata.src_addr = req_q.src_addr;
            mem_wdata.dst_addr = req_q.dst_addr;
            mem_wdata.src_port = req_q.src_port;
            mem_wdata.dst_port = req_q.dst_port;
            mem_wdata.conn_id  = ctr_inc;
            mem_wdata.seq      = req_q.is_tcp ? req_q.tcp_seq : 32'd0;
            out_data_d.has_id  = 1'b1;
            out_data_d.conn_id = ctr_inc;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ctr_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ctr_q       <= ctr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    bypass_q   <= bypass_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    out_data_q <= out_data_d;
  end

  // Table memory: one read or one write per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flow_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= flow_mem_q[mem_raddr];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(FLOW_SLOTS))
    else $error("fill count beyond table size");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("transaction accepted while one is in flight");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result produced outside final state");

  a_full_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.table_full && out_data_o.has_id))
    else $error("table_full together with an id");

  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctr_q != $past(ctr_q)) |-> ($past(state_q) == S_FIN && ctr_q == $past(ctr_q) + 32'd1))
    else $error("id counter moved outside a table update");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfit_pkg::*;

  localparam int SLOTS        = 64;
  localparam int POOL_FLOWS   = 72;
  localparam int N_RANDOM     = 1831;
  localparam int GAP_MAX      = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_PRINTS   = 50;
  localparam longint LIMIT_NS = 64'd10_000_000;

  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
  } tuple_t;

  typedef struct {
    bfit_req_t pkt;
    bit        typed;
    bfit_rsp_t rsp;
  } row_t;

  localparam tuple_t FLOW_A     = 96'hFFFFFFFF_00000000_FFFF_0000;
  localparam tuple_t FLOW_A_REV = 96'h00000000_FFFFFFFF_0000_FFFF;
  localparam tuple_t FLOW_ZERO  = 96'h0;
  localparam tuple_t FLOW_ONES  = {96{1'b1}};
  localparam tuple_t FLOW_C     = 96'hC0A80001_0A000002_1234_0050;
  localparam tuple_t FLOW_C_REV = 96'h0A000002_C0A80001_0050_1234;
  localparam tuple_t FLOW_C_PRT = 96'hC0A80001_0A000002_1234_0051;
  localparam tuple_t FLOW_C_ADR = 96'h0A000002_C0A80001_1234_0050;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  bfit_req_t in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bfit_rsp_t out_data;

  // flow table shadow
  bit          slot_used [SLOTS];
  tuple_t      slot_flow [SLOTS];
  logic [31:0] slot_conn [SLOTS];
  logic [31:0] slot_seq  [SLOTS];
  logic [31:0] last_id = '0;

  tuple_t    flow_pool [POOL_FLOWS];
  row_t      plan [$];
  bfit_rsp_t expected_rsp [$];

  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int n_new      = 0;
  int n_renew    = 0;
  int n_full     = 0;
  int n_none     = 0;
  int n_hit      = 0;
  int n_results  = 0;
  int n_errors   = 0;

  bidirectional_flow_id_table_core #(
    .FLOW_SLOTS(SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("bidirectional_flow_id_table_core verification failed");
    $finish;
  end

  function automatic tuple_t tuple_of(bfit_req_t p);
    return {p.src_addr, p.dst_addr, p.src_port, p.dst_port};
  endfunction

  function automatic bit same_flow(tuple_t k, tuple_t t);
    return (k == t) || (k.sa == t.da && k.da == t.sa && k.sp == t.dp && k.dp == t.sp);
  endfunction

  function automatic int lookup_slot(tuple_t t);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && same_flow(slot_flow[i], t)) return i;
    end
    return -1;
  endfunction

  // Updates the shadow table and returns the id the block should give.
  function automatic bfit_rsp_t assign_conn_id(bfit_req_t p);
    bfit_rsp_t r;
    int        hit;
    int        free_idx;
    r = '0;
    if (!(p.is_ipv4 && p.has_ports)) begin
      n_none++;
      return r;
    end
    hit = lookup_slot(tuple_of(p));
    if (hit >= 0) begin
      if (p.is_tcp && p.syn_flag && !p.ack_flag && slot_seq[hit] != p.tcp_seq) begin
        last_id         = last_id + 32'd1;
        slot_conn[hit]  = last_id;
        slot_seq[hit]   = p.tcp_seq;
        n_renew++;
      end else begin
        n_hit++;
      end
      r.has_id  = 1'b1;
      r.conn_id = slot_conn[hit];
      return r;
    end
    free_idx = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i] && free_idx < 0) free_idx = i;
    end
    if (free_idx < 0) begin
      r.table_full = 1'b1;
      n_full++;
      return r;
    end
    last_id             = last_id + 32'd1;
    slot_used[free_idx] = 1'b1;
    slot_flow[free_idx] = tuple_of(p);
    slot_conn[free_idx] = last_id;
    slot_seq[free_idx]  = p.is_tcp ? p.tcp_seq : 32'd0;
    n_new++;
    r.has_id  = 1'b1;
    r.conn_id = last_id;
    return r;
  endfunction

  function automatic bfit_req_t make_pkt(bit ipv4, bit ports, bit tcp, bit syn, bit ack,
                                         tuple_t t, logic [31:0] seq);
    bfit_req_t p;
    p.is_ipv4   = ipv4;
    p.has_ports = ports;
    p.is_tcp    = tcp;
    p.syn_flag  = syn;
    p.ack_flag  = ack;
    p.src_addr  = t.sa;
    p.dst_addr  = t.da;
    p.src_port  = t.sp;
    p.dst_port  = t.dp;
    p.tcp_seq   = seq;
    return p;
  endfunction

  function automatic bfit_req_t random_packet();
    bfit_req_t p;
    tuple_t    t;
    int        kind;
    int        hit;
    kind        = $urandom_range(0, 99);
    p.is_ipv4   = 1'($urandom_range(0, 1));
    p.has_ports = 1'($urandom_range(0, 1));
    p.is_tcp    = 1'($urandom_range(0, 1));
    p.syn_flag  = 1'($urandom_range(0, 1));
    p.ack_flag  = 1'($urandom_range(0, 1));
    p.src_addr  = $urandom;
    p.dst_addr  = $urandom;
    p.src_port  = 16'($urandom);
    p.dst_port  = 16'($urandom);
    p.tcp_seq   = $urandom;
    // noise: something the block passes through without an id
    if (kind < 8) begin
      if (p.is_ipv4 && p.has_ports) begin
        case ($urandom_range(0, 2))
          0: p.is_ipv4 = 1'b0;
          1: p.has_ports = 1'b0;
          default: begin
            p.is_ipv4   = 1'b0;
            p.has_ports = 1'b0;
          end
        endcase
      end
      return p;
    end
    p.is_ipv4   = 1'b1;
    p.has_ports = 1'b1;
    if (kind >= 13) begin
      t = flow_pool[$urandom_range(0, POOL_FLOWS - 1)];
      if ($urandom_range(0, 1) == 1) t = {t.da, t.sa, t.dp, t.sp};
      p.src_addr = t.sa;
      p.dst_addr = t.da;
      p.src_port = t.sp;
      p.dst_port = t.dp;
    end
    p.is_tcp = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 4))
      0, 1: {p.syn_flag, p.ack_flag} = 2'b10;
      2: {p.syn_flag, p.ack_flag} = 2'b11;
      3: {p.syn_flag, p.ack_flag} = 2'b01;
      default: {p.syn_flag, p.ack_flag} = 2'b00;
    endcase
    // repeat the stored sequence now and then so duplicate SYNs show up
    hit = lookup_slot(tuple_of(p));
    if (hit >= 0 && $urandom_range(0, 2) == 0) p.tcp_seq = slot_seq[hit];
    return p;
  endfunction

  task automatic add_row(input bfit_req_t p, input bit typed, input logic has,
                         input logic [31:0] id, input logic full);
    row_t r;
    r.pkt            = p;
    r.typed          = typed;
    r.rsp.has_id     = has;
    r.rsp.conn_id    = id;
    r.rsp.table_full = full;
    plan.push_back(r);
  endtask

  task automatic offer_packet(input bfit_req_t p, input bit typed, input bfit_rsp_t typed_rsp);
    int        gap;
    bfit_rsp_t predicted;
    if ($urandom_range(0, 99) < 3) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk_i); while (!in_ready);
    predicted = assign_conn_id(p);
    expected_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("[%0t] result %0d: %s got %0h want %0h", $time, n_results, what, got, want);
  endtask

  task automatic check_result(input bfit_rsp_t got);
    bfit_rsp_t want;
    if (expected_rsp.size() == 0) begin
      report_mismatch("unexpected transaction, conn_id", got.conn_id, 32'd0);
      return;
    end
    want = expected_rsp.pop_front();
    if (got.has_id !== want.has_id)
      report_mismatch("has_id", 32'(got.has_id), 32'(want.has_id));
    if (got.conn_id !== want.conn_id)
      report_mismatch("conn_id", got.conn_id, want.conn_id);
    if (got.table_full !== want.table_full)
      report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 99) < 3) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, GAP_MAX);
      // long back-pressure so the table stalls its input
      if (n_results == 150 || n_results == 1200) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      check_result(out_data);
      n_results++;
    end
  end

  initial begin : stimulus
    bfit_req_t pkt;
    bfit_rsp_t no_rsp;
    no_rsp = '0;

    // not eligible for an id
    add_row(make_pkt(0, 1, 1, 1, 0, FLOW_A, 32'h1), 1, 0, 32'd0, 0);
    add_row(make_pkt(1, 0, 1, 1, 0, FLOW_A, 32'h1), 1, 0, 32'd0, 0);
    // UDP flow, seen both ways; stored seq is zero
    add_row(make_pkt(1, 1, 0, 0, 0, FLOW_A, 32'hFFFF_FFFF), 1, 1, 32'd1, 0);
    add_row(make_pkt(1, 1, 0, 0, 0, FLOW_A_REV, 32'h0), 1, 1, 32'd1, 0);
    add_row(make_pkt(1, 1, 1, 1, 0, FLOW_A_REV, 32'h0), 1, 1, 32'd1, 0);
    // SYN on a non-TCP packet is ignored
    add_row(make_pkt(1, 1, 0, 1, 0, FLOW_A, 32'h5), 1, 1, 32'd1, 0);
    add_row(make_pkt(1, 1, 1, 1, 0, FLOW_A, 32'h5), 1, 1, 32'd2, 0);
    add_row(make_pkt(1, 1, 1, 1, 1, FLOW_A, 32'h9), 1, 1, 32'd2, 0);
    // all-zero tuple, then renewal to max seq and a duplicate SYN
    add_row(make_pkt(1, 1, 1, 0, 0, FLOW_ZERO, 32'h0), 1, 1, 32'd3, 0);
    add_row(make_pkt(1, 1, 1, 1, 0, FLOW_ZERO, 32'hFFFF_FFFF), 1, 1, 32'd4, 0);
    add_row(make_pkt(1, 1, 1, 1, 0, FLOW_ZERO, 32'hFFFF_FFFF), 1, 1, 32'd4, 0);
    add_row(make_pkt(1, 1, 1, 1, 0, FLOW_C, 32'd1000), 1, 1, 32'd5, 0);
    add_row(make_pkt(1, 1, 1, 0, 1, FLOW_C_REV, 32'h1234_5678), 1, 1, 32'd5, 0);
    add_row(make_pkt(1, 1, 1, 1, 0, FLOW_C_REV, 32'd2000), 1, 1, 32'd6, 0);
    add_row(make_pkt(0, 0, 1, 1, 0, FLOW_C, 32'd3000), 1, 0, 32'd0, 0);
    add_row(make_pkt(1, 1, 0, 1, 1, FLOW_ONES, 32'hFFFF_FFFF), 1, 1, 32'd7, 0);
    // near misses of FLOW_C are new flows; then FLOW_C itself hits again
    add_row(make_pkt(1, 1, 1, 1, 0, FLOW_C_PRT, 32'd2000), 0, 0, 32'd0, 0);
    add_row(make_pkt(1, 1, 0, 0, 0, FLOW_C_ADR, 32'd0), 0, 0, 32'd0, 0);
    add_row(make_pkt(1, 1, 1, 0, 1, FLOW_C, 32'd2000), 0, 0, 32'd0, 0);

    for (int i = 0; i < POOL_FLOWS; i++) begin
      flow_pool[i].sa = $urandom;
      flow_pool[i].da = $urandom;
      flow_pool[i].sp = 16'($urandom);
      flow_pool[i].dp = 16'($urandom);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) offer_packet(plan[i].pkt, plan[i].typed, plan[i].rsp);
    repeat (N_RANDOM) begin
      pkt = random_packet();
      offer_packet(pkt, 1'b0, no_rsp);
    end
    in_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("packets: %0d new flows, %0d hits, %0d renewed, %0d table full, %0d without id",
             n_new, n_hit, n_renew, n_full, n_none);
    $display("transactions checked: %0d, mismatches: %0d", n_results, n_errors);
    if (n_errors == 0) begin
      $display("bidirectional_flow_id_table_core verification clean");
    end else begin
      $display("bidirectional_flow_id_table_core verification failed");
    end
    $finish;
  end

endmodule
